// File: rtl/bfr_pkg.sv
// Shared types and constants for the bitstream field reader.
// Used by the channel interfaces, controller, datapath and top level; no dependencies.
`timescale 1ns / 1ps

package bfr_pkg;

    localparam int BUFFER_WORDS  = 256;
    localparam int WORD_ADDR_W   = $clog2(BUFFER_WORDS);
    localparam int NEXT_WORD_W   = WORD_ADDR_W + 1;
    localparam int WORD_BITS     = 32;
    localparam int BYTE_BITS     = 8;
    localparam int BYTE_SHIFT    = $clog2(BYTE_BITS);
    localparam int SCRATCH_W     = 2 * WORD_BITS;
    localparam int FILL_W        = $clog2(SCRATCH_W);
    localparam int COUNT_W       = 6;
    localparam int REM_W         = 5;
    localparam int POS_W         = 14;
    localparam int TOTAL_BYTES_W = 11;
    localparam int DIV_CNT_W     = $clog2(POS_W);

    localparam logic [TOTAL_BYTES_W-1:0] TOTAL_BYTES_RESET = TOTAL_BYTES_W'(1024);
    localparam logic [TOTAL_BYTES_W-1:0] CAP_BYTES         = TOTAL_BYTES_W'(BUFFER_WORDS * 4);
    localparam logic [COUNT_W-1:0]       MAX_COUNT         = COUNT_W'(WORD_BITS);
    localparam logic [DIV_CNT_W-1:0]     DIV_LAST_BIT      = DIV_CNT_W'(POS_W - 1);

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_READ    = 2'd1,
        CMD_ALIGN   = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        STS_OK          = 2'd0,
        STS_OVERFLOW    = 2'd1,
        STS_PAD_NONZERO = 2'd2
    } status_code_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REM,
        S_CHECK,
        S_FETCH,
        S_TAKE,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic rem_step;
        logic fetch_rd;
        logic merge;
        logic take;
        logic set_ovf;
        logic push;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic n_zero;
        logic overflow;
        logic need_fetch;
        logic rem_last;
    } dp_sts_t;

endpackage

// File: rtl/bfr_channels.sv
// Valid/ready channel interfaces for command items and result items.
// Depends on bfr_pkg for field widths.
`timescale 1ns / 1ps

interface bfr_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           command;
    logic [bfr_pkg::WORD_ADDR_W-1:0]      word_address;
    logic [bfr_pkg::WORD_BITS-1:0]        word_data;
    logic [bfr_pkg::COUNT_W-1:0]          bit_count;
    logic [bfr_pkg::COUNT_W-1:0]          align_multiple;

    modport source (output valid, command, word_address, word_data, bit_count,
                    align_multiple, input ready);
    modport sink   (input valid, command, word_address, word_data, bit_count,
                    align_multiple, output ready);
endinterface

interface bfr_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [bfr_pkg::WORD_BITS-1:0]        value;
    logic [1:0]                           status;
    logic [bfr_pkg::POS_W-1:0]            bits_consumed;
    logic [bfr_pkg::POS_W-1:0]            bits_left;
    logic [bfr_pkg::TOTAL_BYTES_W-1:0]    bytes_fetched;

    modport source (output valid, value, status, bits_consumed, bits_left, bytes_fetched,
                    input ready);
    modport sink   (input valid, value, status, bits_consumed, bits_left, bytes_fetched,
                    output ready);
endinterface

// File: rtl/bfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/bfr_ctrl.sv
// Controller for the bitstream field reader: sequences each item through the datapath
// and owns the result valid flag. Depends on bfr_pkg.
`timescale 1ns / 1ps

module bfr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [1:0]       req_command,
    output logic             req_ready,
    input  logic             rsp_ready,
    output logic             rsp_valid,
    input  bfr_pkg::dp_sts_t sts,
    output bfr_pkg::dp_cmd_t cmd
);

    bfr_pkg::state_t    state_reg, state_next;
    bfr_pkg::cmd_code_t req_code;
    logic               rsp_valid_reg, rsp_valid_next;
    logic               accept;
    logic               out_free;

    assign req_code  = bfr_pkg::cmd_code_t'(req_command);
    assign req_ready = (state_reg == bfr_pkg::S_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfr_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_code)
                        bfr_pkg::CMD_READ:  state_next = bfr_pkg::S_CHECK;
                        bfr_pkg::CMD_ALIGN: state_next = bfr_pkg::S_REM;
                        default:            state_next = bfr_pkg::S_DONE;
                    endcase
                end
            end
            bfr_pkg::S_REM:
            begin
                if (sts.rem_last)
                begin
                    state_next = bfr_pkg::S_CHECK;
                end
            end
            bfr_pkg::S_CHECK:
            begin
                if (sts.n_zero || sts.overflow)
                begin
                    state_next = bfr_pkg::S_DONE;
                end
                else if (sts.need_fetch)
                begin
                    state_next = bfr_pkg::S_FETCH;
                end
                else
                begin
                    state_next = bfr_pkg::S_TAKE;
                end
            end
            bfr_pkg::S_FETCH: state_next = bfr_pkg::S_TAKE;
            bfr_pkg::S_TAKE:  state_next = bfr_pkg::S_DONE;
            bfr_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = bfr_pkg::S_IDLE;
                end
            end
            default: state_next = bfr_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.capture  = accept;
        cmd.rem_step = (state_reg == bfr_pkg::S_REM);
        cmd.fetch_rd = (state_reg == bfr_pkg::S_CHECK) && !sts.n_zero && !sts.overflow
                       && sts.need_fetch;
        cmd.set_ovf  = (state_reg == bfr_pkg::S_CHECK) && !sts.n_zero && sts.overflow;
        cmd.merge    = (state_reg == bfr_pkg::S_FETCH);
        cmd.take     = (state_reg == bfr_pkg::S_TAKE);
        cmd.push     = (state_reg == bfr_pkg::S_DONE) && out_free;
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.push)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfr_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// File: rtl/bfr_datapath.sv
// Datapath for the bitstream field reader: word buffer, scratch register, position
// counters, serial remainder unit and result register. Depends on bfr_pkg and bfr_ram.
`timescale 1ns / 1ps

module bfr_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bfr_pkg::dp_cmd_t                     cmd,
    output bfr_pkg::dp_sts_t                     sts,
    input  logic                                 cfg_wr_en,
    input  logic [bfr_pkg::TOTAL_BYTES_W-1:0]    cfg_wr_data,
    input  logic [1:0]                           req_command,
    input  logic [bfr_pkg::WORD_ADDR_W-1:0]      req_word_address,
    input  logic [bfr_pkg::WORD_BITS-1:0]        req_word_data,
    input  logic [bfr_pkg::COUNT_W-1:0]          req_bit_count,
    input  logic [bfr_pkg::COUNT_W-1:0]          req_align_multiple,
    output logic [bfr_pkg::WORD_BITS-1:0]        rsp_value,
    output logic [1:0]                           rsp_status,
    output logic [bfr_pkg::POS_W-1:0]            rsp_bits_consumed,
    output logic [bfr_pkg::POS_W-1:0]            rsp_bits_left,
    output logic [bfr_pkg::TOTAL_BYTES_W-1:0]    rsp_bytes_fetched
);

    // reader state
    logic [bfr_pkg::SCRATCH_W-1:0]     scratch_reg, scratch_next;
    logic [bfr_pkg::FILL_W-1:0]        fill_reg, fill_next;
    logic [bfr_pkg::NEXT_WORD_W-1:0]   next_word_reg, next_word_next;
    logic [bfr_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [bfr_pkg::TOTAL_BYTES_W-1:0] total_bytes_reg, total_bytes_next;

    // per-item working registers
    logic [bfr_pkg::COUNT_W-1:0]       n_reg, n_next;
    logic [bfr_pkg::COUNT_W-1:0]       m_reg, m_next;
    logic                              align_reg, align_next;
    logic [bfr_pkg::REM_W-1:0]         rem_reg, rem_next;
    logic [bfr_pkg::POS_W-1:0]         div_reg, div_next;
    logic [bfr_pkg::DIV_CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic [bfr_pkg::WORD_BITS-1:0]     value_reg, value_next;
    bfr_pkg::status_code_t             status_reg, status_next;

    // result register
    logic [bfr_pkg::WORD_BITS-1:0]     out_value_reg;
    logic [1:0]                        out_status_reg;
    logic [bfr_pkg::POS_W-1:0]         out_consumed_reg;
    logic [bfr_pkg::POS_W-1:0]         out_left_reg;
    logic [bfr_pkg::TOTAL_BYTES_W-1:0] out_fetched_reg;

    bfr_pkg::cmd_code_t                req_code;
    logic [bfr_pkg::TOTAL_BYTES_W-1:0] usable_bytes;
    logic [bfr_pkg::POS_W-1:0]         usable_bits;
    logic [bfr_pkg::POS_W:0]           end_pos;
    logic [bfr_pkg::COUNT_W-1:0]       rem_trial;
    logic [bfr_pkg::COUNT_W-1:0]       rem_sub;
    logic [bfr_pkg::WORD_BITS-1:0]     take_mask;
    logic [bfr_pkg::WORD_BITS-1:0]     take_value;
    logic [bfr_pkg::WORD_BITS-1:0]     ram_rd_data;
    logic                              ram_wr_en;

    assign req_code = bfr_pkg::cmd_code_t'(req_command);

    assign usable_bytes = (total_bytes_reg > bfr_pkg::CAP_BYTES) ? bfr_pkg::CAP_BYTES
                                                                  : total_bytes_reg;
    assign usable_bits  = bfr_pkg::POS_W'({usable_bytes, bfr_pkg::BYTE_SHIFT'(0)});
    assign end_pos      = {1'b0, pos_reg} + (bfr_pkg::POS_W + 1)'(n_reg);

    assign sts.n_zero     = (n_reg == '0);
    assign sts.overflow   = (end_pos > {1'b0, usable_bits});
    assign sts.need_fetch = (fill_reg < n_reg);
    assign sts.rem_last   = (div_cnt_reg == '0);

    // one restoring step: bring in the next position bit, subtract the multiple if it fits
    assign rem_trial = {rem_reg, div_reg[bfr_pkg::POS_W-1]};
    assign rem_sub   = (rem_trial >= m_reg) ? (rem_trial - m_reg) : rem_trial;

    assign take_mask  = {bfr_pkg::WORD_BITS{1'b1}} >> (bfr_pkg::MAX_COUNT - n_reg);
    assign take_value = scratch_reg[bfr_pkg::WORD_BITS-1:0] & take_mask;

    assign ram_wr_en = cmd.capture && (req_code == bfr_pkg::CMD_LOAD);

    bfr_ram #(
        .WIDTH (bfr_pkg::WORD_BITS),
        .DEPTH (bfr_pkg::BUFFER_WORDS)
    ) u_word_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (req_word_address),
        .wr_data (req_word_data),
        .rd_en   (cmd.fetch_rd),
        .rd_addr (next_word_reg[bfr_pkg::WORD_ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        scratch_next     = scratch_reg;
        fill_next        = fill_reg;
        next_word_next   = next_word_reg;
        pos_next         = pos_reg;
        total_bytes_next = cfg_wr_en ? cfg_wr_data : total_bytes_reg;
        n_next           = n_reg;
        m_next           = m_reg;
        align_next       = align_reg;
        rem_next         = rem_reg;
        div_next         = div_reg;
        div_cnt_next     = div_cnt_reg;
        value_next       = value_reg;
        status_next      = status_reg;

        if (cmd.capture)
        begin
            value_next   = '0;
            status_next  = bfr_pkg::STS_OK;
            align_next   = (req_code == bfr_pkg::CMD_ALIGN);
            rem_next     = '0;
            div_next     = pos_reg;
            div_cnt_next = bfr_pkg::DIV_LAST_BIT;
            // saturate the read count to one word
            n_next       = (req_bit_count > bfr_pkg::MAX_COUNT) ? bfr_pkg::MAX_COUNT
                                                                : req_bit_count;
            if (req_align_multiple == '0)
            begin
                m_next = bfr_pkg::COUNT_W'(1);
            end
            else if (req_align_multiple > bfr_pkg::MAX_COUNT)
            begin
                m_next = bfr_pkg::MAX_COUNT;
            end
            else
            begin
                m_next = req_align_multiple;
            end
            if (req_code == bfr_pkg::CMD_RESTART)
            begin
                scratch_next   = '0;
                fill_next      = '0;
                next_word_next = '0;
                pos_next       = '0;
            end
        end

        if (cmd.rem_step)
        begin
            rem_next     = rem_sub[bfr_pkg::REM_W-1:0];
            div_next     = {div_reg[bfr_pkg::POS_W-2:0], 1'b0};
            div_cnt_next = div_cnt_reg - 1'b1;
            // last step: turn the remainder into the padding length
            if (div_cnt_reg == '0)
            begin
                n_next = (rem_sub == '0) ? '0 : (m_reg - rem_sub);
            end
        end

        if (cmd.set_ovf)
        begin
            status_next = bfr_pkg::STS_OVERFLOW;
        end

        if (cmd.merge)
        begin
            scratch_next   = scratch_reg
                             | ({bfr_pkg::WORD_BITS'(0), ram_rd_data} << fill_reg);
            fill_next      = fill_reg + bfr_pkg::FILL_W'(bfr_pkg::WORD_BITS);
            next_word_next = next_word_reg + 1'b1;
        end

        if (cmd.take)
        begin
            value_next   = take_value;
            scratch_next = scratch_reg >> n_reg;
            fill_next    = fill_reg - n_reg;
            pos_next     = pos_reg + bfr_pkg::POS_W'(n_reg);
            if (align_reg && (take_value != '0))
            begin
                status_next = bfr_pkg::STS_PAD_NONZERO;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scratch_reg     <= '0;
            fill_reg        <= '0;
            next_word_reg   <= '0;
            pos_reg         <= '0;
            total_bytes_reg <= bfr_pkg::TOTAL_BYTES_RESET;
            div_cnt_reg     <= '0;
        end
        else
        begin
            scratch_reg     <= scratch_next;
            fill_reg        <= fill_next;
            next_word_reg   <= next_word_next;
            pos_reg         <= pos_next;
            total_bytes_reg <= total_bytes_next;
            div_cnt_reg     <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        m_reg      <= m_next;
        align_reg  <= align_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        if (cmd.push)
        begin
            out_value_reg    <= value_reg;
            out_status_reg   <= status_reg;
            out_consumed_reg <= pos_reg;
            out_left_reg     <= (pos_reg < usable_bits) ? (usable_bits - pos_reg) : '0;
            out_fetched_reg  <= bfr_pkg::TOTAL_BYTES_W'({next_word_reg, 2'b00});
        end
    end

    assign rsp_value         = out_value_reg;
    assign rsp_status        = out_status_reg;
    assign rsp_bits_consumed = out_consumed_reg;
    assign rsp_bits_left     = out_left_reg;
    assign rsp_bytes_fetched = out_fetched_reg;

endmodule

// File: rtl/bitstream_field_reader_unit.sv
// Top level of the bitstream field reader: command and result channels, length register.
// Depends on bfr_pkg, bfr_channels, bfr_ctrl and bfr_datapath.
//
// Unpacks fields of 1 to 32 bits, least significant bit first, from a 256-word packet
// buffer that load items fill. Items are handled one at a time and each returns exactly
// one result item, which waits in an output register; the next item is taken the cycle
// after the previous result is written there. Loads and restarts go to done. A read
// passes check, take and done, plus fetch when the scratch register must pull another
// word through the buffer RAM's registered read port; an overflow or zero-bit read skips
// to done. An align first runs the remainder unit over the 14-bit position, one bit per
// cycle, then reads its padding. total_bytes may only be written while no item is in
// flight; a length below the current position makes every nonempty read overflow.
`timescale 1ns / 1ps

module bitstream_field_reader_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    bfr_req_if.sink                           request,
    bfr_rsp_if.source                         response,
    input  logic                              cfg_wr_en,
    input  logic [bfr_pkg::TOTAL_BYTES_W-1:0] cfg_wr_data
);

    bfr_pkg::dp_cmd_t dp_cmd;
    bfr_pkg::dp_sts_t dp_sts;

    bfr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (request.valid),
        .req_command (request.command),
        .req_ready   (request.ready),
        .rsp_ready   (response.ready),
        .rsp_valid   (response.valid),
        .sts         (dp_sts),
        .cmd         (dp_cmd)
    );

    bfr_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (dp_cmd),
        .sts                (dp_sts),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .req_command        (request.command),
        .req_word_address   (request.word_address),
        .req_word_data      (request.word_data),
        .req_bit_count      (request.bit_count),
        .req_align_multiple (request.align_multiple),
        .rsp_value          (response.value),
        .rsp_status         (response.status),
        .rsp_bits_consumed  (response.bits_consumed),
        .rsp_bits_left      (response.bits_left),
        .rsp_bytes_fetched  (response.bytes_fetched)
    );

endmodule

// File: sim/bitstream_field_reader_unit_tb.sv
// Self-checking testbench for bitstream_field_reader_unit: load, read, align and restart items
// against a cycle-free predictor of the LSB-first field unpacker, with random idling.
// Depends on bfr_pkg, bfr_channels and the RTL of the unit.
`timescale 1ns / 1ps

module bitstream_field_reader_unit_tb;
    import bfr_pkg::*;

    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PRINT_LIMIT   = 40;

    typedef struct packed {
        cmd_code_t                command;
        logic [WORD_ADDR_W-1:0]   word_address;
        logic [WORD_BITS-1:0]     word_data;
        logic [COUNT_W-1:0]       bit_count;
        logic [COUNT_W-1:0]       align_multiple;
    } field_cmd_t;

    typedef struct packed {
        logic [WORD_BITS-1:0]     value;
        status_code_t             status;
        logic [POS_W-1:0]         bits_consumed;
        logic [POS_W-1:0]         bits_left;
        logic [TOTAL_BYTES_W-1:0] bytes_fetched;
    } field_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_wr_en;
    logic [TOTAL_BYTES_W-1:0] cfg_wr_data;

    bfr_req_if req_ch ();
    bfr_rsp_if rsp_ch ();

    bitstream_field_reader_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (req_ch),
        .response    (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // Predictor state: buffer, scratch register and read cursor as the block keeps them
    logic [WORD_BITS-1:0]     stream_words [BUFFER_WORDS];
    logic [SCRATCH_W-1:0]     stream_scratch = '0;
    int                       scratch_bits = 0;
    int                       words_pulled = 0;
    int                       bit_position = 0;
    logic [TOTAL_BYTES_W-1:0] length_bytes = TOTAL_BYTES_RESET;

    // Stimulus planning state: tracks the cursor ahead of time so no unloaded word is fetched
    int                       plan_position = 0;
    int                       plan_fill = 0;
    int                       plan_next = 0;
    int                       plan_bits = 0;
    bit                       plan_loaded [BUFFER_WORDS];

    field_cmd_t               pending_q [$];
    field_result_t            expected_q [$];
    field_cmd_t               next_cmd;
    field_cmd_t               seen_cmd;
    field_result_t            seen_result;

    int  issued_count = 0;
    int  accepted_count = 0;
    int  result_count = 0;
    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  read_count = 0;
    int  align_count = 0;
    int  load_count = 0;
    int  restart_count = 0;
    int  overflow_count = 0;
    int  padflag_count = 0;
    int  deepest_position = 0;
    int  length_settings = 1;
    int  send_gap = 0;
    int  send_calm = 0;
    int  hold_gap = 0;
    int  hold_calm = 0;
    logic req_taken = 1'b0;
    logic rsp_taken = 1'b0;

    function automatic int usable_bits(input logic [TOTAL_BYTES_W-1:0] bytes);
        int capped;
        capped = (int'(bytes) > BUFFER_WORDS * 4) ? BUFFER_WORDS * 4 : int'(bytes);
        return capped * BYTE_BITS;
    endfunction

    function automatic int clamp_count(input logic [COUNT_W-1:0] n);
        return (n > MAX_COUNT) ? WORD_BITS : int'(n);
    endfunction

    // Take n bits off the bottom of the scratch register, refilling one word when short
    function automatic logic [WORD_BITS-1:0] pull_bits(input int n);
        logic [SCRATCH_W-1:0] mask;
        logic [WORD_BITS-1:0] field;
        bit_position += n;
        if (scratch_bits < n)
        begin
            stream_scratch |= SCRATCH_W'(stream_words[words_pulled % BUFFER_WORDS]) << scratch_bits;
            scratch_bits += WORD_BITS;
            words_pulled++;
        end
        mask = (SCRATCH_W'(1) << n) - SCRATCH_W'(1);
        field = WORD_BITS'(stream_scratch & mask);
        stream_scratch >>= n;
        scratch_bits -= n;
        return field;
    endfunction

    function automatic field_result_t predict_result(input field_cmd_t c);
        field_result_t r;
        int            n;
        int            usable;
        r = '0;
        usable = usable_bits(length_bytes);
        case (c.command)
            CMD_LOAD:
                stream_words[c.word_address] = c.word_data;
            CMD_READ:
            begin
                n = clamp_count(c.bit_count);
                if (n != 0)
                begin
                    if (bit_position + n > usable)
                        r.status = STS_OVERFLOW;
                    else
                        r.value = pull_bits(n);
                end
            end
            CMD_ALIGN:
            begin
                n = (c.align_multiple == 0) ? 1 : clamp_count(c.align_multiple);
                if (bit_position % n != 0)
                begin
                    n = n - bit_position % n;
                    if (bit_position + n > usable)
                        r.status = STS_OVERFLOW;
                    else
                    begin
                        r.value = pull_bits(n);
                        if (r.value != 0)
                            r.status = STS_PAD_NONZERO;
                    end
                end
            end
            default:
            begin
                stream_scratch = '0;
                scratch_bits = 0;
                words_pulled = 0;
                bit_position = 0;
            end
        endcase
        r.bits_consumed = POS_W'(bit_position);
        r.bits_left = (bit_position < usable) ? POS_W'(usable - bit_position) : '0;
        r.bytes_fetched = TOTAL_BYTES_W'(words_pulled * 4);
        return r;
    endfunction

    function automatic logic [WORD_BITS-1:0] random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            return '0;
        else if (pick < 35)
            return '1;
        return WORD_BITS'($urandom);
    endfunction

    // Mostly no pause or a short one, a few long ones, and now and then a stretch with none at all
    function automatic int pick_pause(inout int calm);
        int pick;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        else if (pick < 60)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_cmd(input cmd_code_t cmd, input logic [WORD_ADDR_W-1:0] addr,
                            input logic [WORD_BITS-1:0] data, input logic [COUNT_W-1:0] count,
                            input logic [COUNT_W-1:0] mult);
        field_cmd_t c;
        c.command = cmd;
        c.word_address = addr;
        c.word_data = data;
        c.bit_count = count;
        c.align_multiple = mult;
        pending_q.push_back(c);
        issued_count++;
    endtask

    task automatic plan_take(input int n);
        int idx;
        if (plan_position + n > plan_bits)
            return;
        if (plan_fill < n)
        begin
            idx = plan_next % BUFFER_WORDS;
            // load the word first if this take is the one that fetches it
            if (!plan_loaded[idx])
                push_cmd(CMD_LOAD, WORD_ADDR_W'(idx), random_word(), COUNT_W'($urandom),
                         COUNT_W'($urandom));
            plan_loaded[idx] = 1'b1;
            plan_fill += WORD_BITS;
            plan_next++;
        end
        plan_fill -= n;
        plan_position += n;
    endtask

    task automatic queue_cmd(input cmd_code_t cmd, input logic [WORD_ADDR_W-1:0] addr,
                             input logic [WORD_BITS-1:0] data, input logic [COUNT_W-1:0] count,
                             input logic [COUNT_W-1:0] mult);
        int m;
        case (cmd)
            CMD_LOAD:
                plan_loaded[addr] = 1'b1;
            CMD_READ:
                if (count != 0)
                    plan_take(clamp_count(count));
            CMD_ALIGN:
            begin
                m = (mult == 0) ? 1 : clamp_count(mult);
                if (plan_position % m != 0)
                    plan_take(m - plan_position % m);
            end
            default:
            begin
                plan_position = 0;
                plan_fill = 0;
                plan_next = 0;
            end
        endcase
        push_cmd(cmd, addr, data, count, mult);
    endtask

    task automatic queue_random_cmd(input int restart_pct);
        int                     pick;
        cmd_code_t              cmd;
        logic [WORD_ADDR_W-1:0] addr;
        logic [COUNT_W-1:0]     count;
        logic [COUNT_W-1:0]     mult;
        pick = $urandom_range(0, 99);
        addr = WORD_ADDR_W'($urandom);
        count = COUNT_W'($urandom);
        mult = COUNT_W'($urandom);
        if (pick < restart_pct)
            cmd = CMD_RESTART;
        else if (pick < 18)
        begin
            cmd = CMD_LOAD;
            // half the loads land just ahead of the fetch point so reads see them
            if ($urandom_range(0, 1) == 1)
                addr = WORD_ADDR_W'(plan_next + $urandom_range(0, 3));
        end
        else if (pick < 78)
        begin
            cmd = CMD_READ;
            pick = $urandom_range(0, 99);
            if (pick < 5)
                count = '0;
            else if (pick < 15)
                count = COUNT_W'($urandom_range(33, 63));
            else
                count = COUNT_W'($urandom_range(1, 32));
        end
        else
        begin
            cmd = CMD_ALIGN;
            pick = $urandom_range(0, 99);
            if (pick < 5)
                mult = '0;
            else if (pick < 10)
                mult = COUNT_W'($urandom_range(33, 63));
            else if (pick < 40)
                mult = COUNT_W'(8 << $urandom_range(0, 2));
            else
                mult = COUNT_W'($urandom_range(1, 32));
        end
        queue_cmd(cmd, addr, random_word(), count, mult);
    endtask

    task automatic wait_drained();
        while (accepted_count != issued_count || expected_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_length(input int bytes);
        wait_drained();
        // let the last item leave the pipeline before touching the register
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_data <= TOTAL_BYTES_W'(bytes);
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        plan_bits = usable_bits(TOTAL_BYTES_W'(bytes));
        length_settings++;
    endtask

    task automatic report_mismatch(input string what, input logic [WORD_BITS-1:0] want,
                                   input logic [WORD_BITS-1:0] got);
        if (mismatch_count < PRINT_LIMIT)
            $display("MISMATCH %s at result %0d: expected 0x%0h, got 0x%0h",
                     what, result_count, want, got);
        mismatch_count++;
    endtask

    task automatic compare_field(input string what, input logic [WORD_BITS-1:0] want,
                                 input logic [WORD_BITS-1:0] got);
        if (got !== want)
            report_mismatch(what, want, got);
    endtask

    task automatic check_result();
        field_result_t want;
        if (expected_q.size() == 0)
            report_mismatch("result with nothing pending", '0, rsp_ch.value);
        else
        begin
            want = expected_q.pop_front();
            compare_field("value", want.value, rsp_ch.value);
            compare_field("status", WORD_BITS'(want.status), WORD_BITS'(rsp_ch.status));
            compare_field("bits_consumed", WORD_BITS'(want.bits_consumed),
                          WORD_BITS'(rsp_ch.bits_consumed));
            compare_field("bits_left", WORD_BITS'(want.bits_left), WORD_BITS'(rsp_ch.bits_left));
            compare_field("bytes_fetched", WORD_BITS'(want.bytes_fetched),
                          WORD_BITS'(rsp_ch.bytes_fetched));
        end
        result_count++;
    endtask

    // Command driver: hold an item until it is taken, then pause or send the next one
    always @(negedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_taken)
        begin
            if (send_gap > 0)
            begin
                req_ch.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_q.size() != 0)
            begin
                next_cmd = pending_q.pop_front();
                req_ch.command <= next_cmd.command;
                req_ch.word_address <= next_cmd.word_address;
                req_ch.word_data <= next_cmd.word_data;
                req_ch.bit_count <= next_cmd.bit_count;
                req_ch.align_multiple <= next_cmd.align_multiple;
                req_ch.valid <= 1'b1;
                send_gap <= pick_pause(send_calm);
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Result back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_gap > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_gap <= hold_gap - 1;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if (rsp_taken)
                hold_gap <= pick_pause(hold_calm);
            else if ($urandom_range(0, 24) == 0)
                hold_gap <= $urandom_range(1, 4);
        end
    end

    // Monitor: predict on each accepted item, check each accepted result
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_q.size());
            $display("status: fail");
            $finish;
        end
        else
        begin
            req_taken <= rst_n & req_ch.valid & req_ch.ready;
            rsp_taken <= rst_n & rsp_ch.valid & rsp_ch.ready;
            if (rst_n)
            begin
                if (rsp_ch.valid && rsp_ch.ready)
                    check_result();
                if (req_ch.valid && req_ch.ready)
                begin
                    seen_cmd.command = cmd_code_t'(req_ch.command);
                    seen_cmd.word_address = req_ch.word_address;
                    seen_cmd.word_data = req_ch.word_data;
                    seen_cmd.bit_count = req_ch.bit_count;
                    seen_cmd.align_multiple = req_ch.align_multiple;
                    seen_result = predict_result(seen_cmd);
                    expected_q.push_back(seen_result);
                    accepted_count++;
                    case (seen_cmd.command)
                        CMD_LOAD:  load_count++;
                        CMD_READ:  read_count++;
                        CMD_ALIGN: align_count++;
                        default:   restart_count++;
                    endcase
                    if (seen_result.status == STS_OVERFLOW)
                        overflow_count++;
                    if (seen_result.status == STS_PAD_NONZERO)
                        padflag_count++;
                    if (int'(seen_result.bits_consumed) > deepest_position)
                        deepest_position = int'(seen_result.bits_consumed);
                end
                if (cfg_wr_en)
                    length_bytes = cfg_wr_data;
            end
        end
    end

    initial
    begin
        int lengths [8];
        int counts [8];
        int restart_pct [8];
        lengths = '{1024, 2047, 37, 0, 1, 0, 1023, 0};
        lengths[5] = $urandom_range(2, 200);
        lengths[7] = $urandom_range(0, 2047);
        counts = '{300, 700, 60, 40, 60, 300, 300, 100};
        restart_pct = '{0, 0, 5, 5, 5, 3, 1, 2};
        plan_bits = usable_bits(TOTAL_BYTES_RESET);
        foreach (plan_loaded[i])
            plan_loaded[i] = 1'b0;

        req_ch.valid = 1'b0;
        req_ch.command = CMD_LOAD;
        req_ch.word_address = '0;
        req_ch.word_data = '0;
        req_ch.bit_count = '0;
        req_ch.align_multiple = '0;
        rsp_ch.ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, zero and oversized counts, align corner cases
        queue_cmd(CMD_LOAD, 8'd255, 32'h0000_0000, 6'd0, 6'd0);
        queue_cmd(CMD_LOAD, 8'd0, 32'hA5C3_0F81, 6'd0, 6'd0);
        queue_cmd(CMD_LOAD, 8'd1, 32'hFFFF_FFFF, 6'd0, 6'd0);
        queue_cmd(CMD_LOAD, 8'd2, 32'h0000_0000, 6'd0, 6'd0);
        queue_cmd(CMD_READ, 8'd0, 32'h0, 6'd0, 6'd0);
        queue_cmd(CMD_READ, 8'd0, 32'h0, 6'd1, 6'd0);
        queue_cmd(CMD_ALIGN, 8'd0, 32'h0, 6'd0, 6'd0);
        queue_cmd(CMD_ALIGN, 8'd0, 32'h0, 6'd0, 6'd8);
        queue_cmd(CMD_READ, 8'd0, 32'h0, 6'd32, 6'd0);
        queue_cmd(CMD_READ, 8'd0, 32'h0, 6'd63, 6'd0);
        queue_cmd(CMD_ALIGN, 8'd0, 32'h0, 6'd0, 6'd32);
        queue_cmd(CMD_ALIGN, 8'd0, 32'h0, 6'd0, 6'd63);
        queue_cmd(CMD_ALIGN, 8'd0, 32'h0, 6'd0, 6'd1);
        queue_cmd(CMD_RESTART, 8'd0, 32'h0, 6'd0, 6'd0);
        queue_cmd(CMD_READ, 8'd0, 32'h0, 6'd32, 6'd0);
        queue_cmd(CMD_READ, 8'd0, 32'h0, 6'd5, 6'd0);
        queue_cmd(CMD_ALIGN, 8'd0, 32'h0, 6'd0, 6'd16);
        queue_cmd(CMD_READ, 8'd0, 32'h0, 6'd16, 6'd0);
        queue_cmd(CMD_READ, 8'd0, 32'h0, 6'd3, 6'd0);
        queue_cmd(CMD_ALIGN, 8'd0, 32'h0, 6'd0, 6'd8);
        queue_cmd(CMD_READ, 8'd0, 32'h0, 6'd33, 6'd0);
        queue_cmd(CMD_ALIGN, 8'd0, 32'h0, 6'd0, 6'd5);

        // Random phases; the cursor carries over so later lengths may fall below it
        for (int p = 0; p < 8; p++)
        begin
            if (p != 0)
                write_length(lengths[p]);
            repeat (counts[p]) queue_random_cmd(restart_pct[p]);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("covered %0d items over %0d length settings: %0d loads, %0d reads, %0d aligns, %0d restarts",
                 accepted_count, length_settings, load_count, read_count, align_count,
                 restart_count);
        $display("saw %0d overflow and %0d nonzero-padding results, deepest position %0d bits",
                 overflow_count, padflag_count, deepest_position);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/bfr_pkg.sv
rtl/bfr_channels.sv
rtl/bfr_ram.sv
rtl/bfr_ctrl.sv
rtl/bfr_datapath.sv
rtl/bitstream_field_reader_unit.sv
sim/bitstream_field_reader_unit_tb.sv
